// ===== hdl/eds_pkg.sv =====
// eds_pkg: shared types and constants for the elevator disk scheduler
// no dependencies; imported by every module of the block

package eds_pkg;

    localparam int MAX_REQUESTS = 16;
    localparam int TRACK_BITS   = 12;
    localparam int ID_BITS      = 8;
    localparam int SUM_BITS     = 16;
    localparam int IDX_BITS     = (MAX_REQUESTS > 1) ? $clog2(MAX_REQUESTS) : 1;
    localparam int CNT_BITS     = $clog2(MAX_REQUESTS + 1);

    typedef enum logic [1:0] {
        S_LOAD,
        S_SCAN,
        S_DONE
    } t_state;

    typedef struct packed {
        logic [ID_BITS-1:0]    req_id;
        logic [TRACK_BITS-1:0] req_track;
        logic                  last_request;
    } t_request;

    typedef struct packed {
        logic [ID_BITS-1:0]    served_id;
        logic [TRACK_BITS-1:0] served_track;
        logic [TRACK_BITS-1:0] seek_distance;
        logic [SUM_BITS-1:0]   seek_total;
        logic                  last_served;
    } t_result;

    typedef struct packed {
        logic                  valid;
        logic                  served;
        logic [TRACK_BITS-1:0] track;
        logic [ID_BITS-1:0]    label;
    } t_entry;

    typedef struct packed {
        logic clear;
        logic load;
        logic shift;
    } t_cell_ctl;

    typedef struct packed {
        logic                  step;
        logic                  first;
        logic [IDX_BITS-1:0]   idx;
        logic [TRACK_BITS-1:0] head;
    } t_scan;

    typedef struct packed {
        logic                  found;
        logic [IDX_BITS-1:0]   idx;
        logic [TRACK_BITS-1:0] track;
        logic [ID_BITS-1:0]    label;
        logic [TRACK_BITS-1:0] delta;
    } t_cand;

    typedef struct packed {
        t_cand up;
        t_cand dn;
    } t_pick;

endpackage

// ===== hdl/eds_cell.sv =====
// eds_cell: one stored request in the rotating ring of entries
// depends on eds_pkg

module eds_cell (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  eds_pkg::t_cell_ctl i_ctl,
    input  eds_pkg::t_entry    i_load_data,
    input  eds_pkg::t_entry    i_next,
    output eds_pkg::t_entry    o_entry
);
    import eds_pkg::*;

    t_entry r_entry;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_entry.valid  <= 1'b0;
            r_entry.served <= 1'b0;
        end else if (i_ctl.clear) begin
            r_entry.valid  <= 1'b0;
            r_entry.served <= 1'b0;
        end else if (i_ctl.load) begin
            r_entry <= i_load_data;
        end else if (i_ctl.shift) begin
            r_entry <= i_next;
        end
    end

    assign o_entry = r_entry;

endmodule

// ===== hdl/eds_pick.sv =====
// eds_pick: nearest-above and nearest-below search over entries passing the ring head
// depends on eds_pkg

module eds_pick (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  eds_pkg::t_scan  i_scan,
    input  eds_pkg::t_entry i_entry,
    output eds_pkg::t_pick  o_pick
);
    import eds_pkg::*;

    t_cand r_up, n_up;
    t_cand r_dn, n_dn;

    always_comb begin
        t_cand                 base_up;
        t_cand                 base_dn;
        logic [TRACK_BITS-1:0] d_up;
        logic [TRACK_BITS-1:0] d_dn;
        logic                  live;
        base_up = r_up;
        base_dn = r_dn;
        if (i_scan.first) begin
            base_up.found = 1'b0;
            base_dn.found = 1'b0;
        end
        d_up = i_entry.track - i_scan.head;
        d_dn = i_scan.head - i_entry.track;
        live = i_entry.valid && !i_entry.served;
        n_up = r_up;
        n_dn = r_dn;
        if (i_scan.step) begin
            n_up = base_up;
            n_dn = base_dn;
            if (live && (i_entry.track >= i_scan.head) &&
                (!base_up.found || d_up < base_up.delta)) begin
                n_up = '{found: 1'b1, idx: i_scan.idx, track: i_entry.track,
                         label: i_entry.label, delta: d_up};
            end
            if (live && (i_entry.track <= i_scan.head) &&
                (!base_dn.found || d_dn < base_dn.delta)) begin
                n_dn = '{found: 1'b1, idx: i_scan.idx, track: i_entry.track,
                         label: i_entry.label, delta: d_dn};
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_up.found <= 1'b0;
            r_dn.found <= 1'b0;
        end else begin
            r_up <= n_up;
            r_dn <= n_dn;
        end
    end

    assign o_pick = '{up: r_up, dn: r_dn};

endmodule

// ===== hdl/elevator_disk_scheduler_top.sv =====
// elevator_disk_scheduler_top: request ring, search unit, sequencer and result register
// depends on eds_pkg, eds_cell, eds_pick

// Requests load one beat per cycle while the input is not stalled, into a ring of
// MAX_REQUESTS cells; a request beyond capacity is dropped, and the beat marked
// last_request closes the batch. Scheduling then rotates the ring once past the search
// unit for every result, and the decision that follows waits while the output is stalled.
// The input is stalled from the last beat of a batch until its final result is in the
// output register. start_track is sampled when the last beat is taken. No clearing pass
// after reset.

module elevator_disk_scheduler_top (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_cfg_we,
    input  logic [eds_pkg::TRACK_BITS-1:0] i_cfg_wdata,
    input  logic                           i_in_valid,
    output logic                           o_in_stall,
    input  eds_pkg::t_request              i_in_data,
    output logic                           o_out_valid,
    input  logic                           i_out_stall,
    output eds_pkg::t_result               o_out_data
);
    import eds_pkg::*;

    localparam logic [IDX_BITS-1:0] LAST_IDX = IDX_BITS'(MAX_REQUESTS - 1);

    t_state r_state, n_state;

    logic [CNT_BITS-1:0]   r_count;
    logic [CNT_BITS-1:0]   r_k;
    logic [IDX_BITS-1:0]   r_idx;
    logic                  r_dir;
    logic [TRACK_BITS-1:0] r_head;
    logic [SUM_BITS-1:0]   r_sum;
    logic [TRACK_BITS-1:0] r_start;
    logic                  r_pend_valid;
    logic [IDX_BITS-1:0]   r_pend_idx;
    logic                  r_out_valid;
    t_result               r_out;

    t_entry    w_cell [MAX_REQUESTS];
    t_entry    w_next [MAX_REQUESTS];
    t_entry    w_eff;
    t_entry    w_load_data;
    t_cell_ctl w_ctl  [MAX_REQUESTS];
    t_scan     w_scan;
    t_pick     w_pick;
    t_cand     w_sel;

    logic in_accept;
    logic out_free;
    logic found_any;
    logic take_up;
    logic last_k;
    logic scan_step;
    logic out_load;
    logic batch_done;
    logic [SUM_BITS-1:0] n_sum;

    assign in_accept = i_in_valid && !o_in_stall;
    assign out_free  = !r_out_valid || !i_out_stall;
    assign found_any = w_pick.up.found || w_pick.dn.found;
    assign take_up   = w_pick.up.found && (r_dir || !w_pick.dn.found);
    assign w_sel     = take_up ? w_pick.up : w_pick.dn;
    assign last_k    = (r_k + CNT_BITS'(1)) == r_count;
    assign n_sum     = r_sum + SUM_BITS'(w_sel.delta);

    // ring head, with the last pick marked served as it goes by
    always_comb begin
        w_eff        = w_cell[0];
        w_eff.served = w_cell[0].served || (r_pend_valid && r_idx == r_pend_idx);
    end

    assign w_load_data = '{valid: 1'b1, served: 1'b0, track: i_in_data.req_track,
                           label: i_in_data.req_id};

    genvar gi;
    generate
        for (gi = 0; gi < MAX_REQUESTS; gi++) begin : g_cell
            if (gi == MAX_REQUESTS - 1) begin : g_tail
                assign w_next[gi] = w_eff;
            end else begin : g_mid
                assign w_next[gi] = w_cell[gi + 1];
            end
            assign w_ctl[gi] = '{clear: batch_done,
                                 load:  in_accept && (r_count == CNT_BITS'(gi)),
                                 shift: scan_step};
            eds_cell u_cell (
                .i_clk       (i_clk),
                .i_rst_n     (i_rst_n),
                .i_ctl       (w_ctl[gi]),
                .i_load_data (w_load_data),
                .i_next      (w_next[gi]),
                .o_entry     (w_cell[gi])
            );
        end
    endgenerate

    assign w_scan = '{step: scan_step, first: r_idx == '0, idx: r_idx, head: r_head};

    eds_pick u_pick (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_scan  (w_scan),
        .i_entry (w_eff),
        .o_pick  (w_pick)
    );

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_LOAD: begin
                if (in_accept && i_in_data.last_request) n_state = S_SCAN;
            end
            S_SCAN: begin
                if (r_idx == LAST_IDX) n_state = S_DONE;
            end
            S_DONE: begin
                if (!found_any) n_state = S_LOAD;
                else if (out_free) n_state = last_k ? S_LOAD : S_SCAN;
            end
            default: n_state = S_LOAD;
        endcase
    end

    always_comb begin
        o_in_stall = 1'b1;
        scan_step  = 1'b0;
        out_load   = 1'b0;
        batch_done = 1'b0;
        unique case (r_state)
            S_LOAD: o_in_stall = 1'b0;
            S_SCAN: scan_step = 1'b1;
            S_DONE: begin
                out_load   = found_any && out_free;
                batch_done = !found_any || (out_free && last_k);
            end
            default: o_in_stall = 1'b1;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_LOAD;
            r_count      <= '0;
            r_k          <= '0;
            r_idx        <= '0;
            r_dir        <= 1'b1;
            r_head       <= '0;
            r_sum        <= '0;
            r_start      <= '0;
            r_pend_valid <= 1'b0;
            r_pend_idx   <= '0;
            r_out_valid  <= 1'b0;
        end else begin
            r_state <= n_state;
            if (i_cfg_we) r_start <= i_cfg_wdata;
            if (in_accept && r_count < CNT_BITS'(MAX_REQUESTS)) r_count <= r_count + CNT_BITS'(1);
            if (in_accept && i_in_data.last_request) begin
                r_head       <= r_start;
                r_dir        <= 1'b1;
                r_sum        <= '0;
                r_k          <= '0;
                r_idx        <= '0;
                r_pend_valid <= 1'b0;
            end
            if (scan_step) r_idx <= (r_idx == LAST_IDX) ? '0 : r_idx + IDX_BITS'(1);
            if (out_load) begin
                r_head       <= w_sel.track;
                r_sum        <= n_sum;
                r_k          <= r_k + CNT_BITS'(1);
                r_dir        <= take_up;
                r_pend_idx   <= w_sel.idx;
                r_pend_valid <= 1'b1;
            end
            if (batch_done) begin
                r_count      <= '0;
            end
            if (out_load) r_out_valid <= 1'b1;
            else if (!i_out_stall) r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_load) begin
            r_out <= '{served_id: w_sel.label, served_track: w_sel.track,
                       seek_distance: w_sel.delta, seek_total: n_sum,
                       last_served: last_k};
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

`ifndef SYNTHESIS
    a_count_cap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CNT_BITS'(MAX_REQUESTS))
        else $error("entry count above capacity");
    a_busy_has_entries: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state != S_LOAD |-> r_count != '0 && r_k < r_count)
        else $error("scheduling with no pending entries");
    a_head_follows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        out_load |=> o_out_valid && r_head == o_out_data.served_track)
        else $error("head not moved to served track");
    a_last_ends: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        out_load && last_k |=> r_state == S_LOAD && r_count == '0)
        else $error("batch not closed after final result");
`endif

endmodule

// ===== dv/elevator_disk_scheduler_top_tb.sv =====
`timescale 1ns / 100ps
// elevator_disk_scheduler_top_tb: feeds request batches to the elevator scheduler and checks
// each served beat against an in-bench scan-order model under random idling and backpressure
// depends on eds_pkg and elevator_disk_scheduler_top

module elevator_disk_scheduler_top_tb;
    import eds_pkg::*;

    localparam int WATCHDOG_LIMIT = 3000;
    localparam int QUIET_CYCLES   = MAX_REQUESTS + 4;
    localparam int HOLD_CYCLES    = 400;
    localparam logic [TRACK_BITS-1:0] TRACK_MAX = '1;
    localparam logic [ID_BITS-1:0]    ID_MAX    = '1;

    logic                  i_clk = 1'b0;
    logic                  i_rst_n;
    logic                  i_cfg_we;
    logic [TRACK_BITS-1:0] i_cfg_wdata;
    logic                  i_in_valid;
    logic                  o_in_stall;
    t_request              i_in_data;
    logic                  o_out_valid;
    logic                  i_out_stall;
    t_result               o_out_data;

    logic [TRACK_BITS-1:0] head_start;
    logic [TRACK_BITS-1:0] batch_tracks[$];
    logic [ID_BITS-1:0]    batch_ids[$];
    t_result               pending_services[$];
    t_result               service_want;

    int error_count      = 0;
    int services_checked = 0;
    int batches_closed   = 0;
    int dropped_requests = 0;
    int start_writes     = 0;
    int idle_cycles      = 0;
    int stall_hold_len   = 0;
    bit in_idling        = 1'b1;
    bit out_idling       = 1'b1;

    elevator_disk_scheduler_top dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_in_data   (i_in_data),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_data  (o_out_data)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // scan order of the closed batch: nearest in the current direction, reverse when none
    function automatic void plan_service_order();
        logic [TRACK_BITS-1:0] head;
        logic [TRACK_BITS-1:0] seek;
        logic [TRACK_BITS-1:0] best;
        logic [SUM_BITS-1:0]   total;
        logic                  going_up;
        bit                    served[MAX_REQUESTS];
        int                    n;
        int                    sel;
        int                    k;
        int                    i;
        int                    pass;
        t_result               svc;
        n = batch_tracks.size();
        head = head_start;
        going_up = 1'b1;
        total = '0;
        best = '0;
        foreach (served[j]) served[j] = 1'b0;
        for (k = 0; k < n; k++) begin
            sel = -1;
            for (pass = 0; pass < 2 && sel < 0; pass++) begin
                if (pass == 1) going_up = !going_up;
                for (i = 0; i < n; i++) begin
                    if (served[i]) continue;
                    if (going_up && batch_tracks[i] >= head) seek = batch_tracks[i] - head;
                    else if (!going_up && batch_tracks[i] <= head) seek = head - batch_tracks[i];
                    else continue;
                    if (sel < 0 || seek < best) begin
                        sel = i;
                        best = seek;
                    end
                end
            end
            if (sel < 0) break;
            served[sel] = 1'b1;
            total = total + SUM_BITS'(best);
            head = batch_tracks[sel];
            svc.served_id     = batch_ids[sel];
            svc.served_track  = head;
            svc.seek_distance = best;
            svc.seek_total    = total;
            svc.last_served   = (k == n - 1);
            pending_services.push_back(svc);
        end
        batch_tracks.delete();
        batch_ids.delete();
        batches_closed++;
    endfunction

    task automatic send_request(input logic [ID_BITS-1:0] id, input logic [TRACK_BITS-1:0] track,
                                input logic is_last);
        t_request beat;
        int       gap;
        beat.req_id       = id;
        beat.req_track    = track;
        beat.last_request = is_last;
        gap = (in_idling && $urandom_range(0, 3) == 0) ? $urandom_range(1, 18) : 0;
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in_data  <= beat;
        @(posedge i_clk);
        while (o_in_stall) @(posedge i_clk);
        if (batch_tracks.size() < MAX_REQUESTS) begin
            batch_tracks.push_back(track);
            batch_ids.push_back(id);
        end else begin
            dropped_requests++;
        end
        if (is_last) plan_service_order();
    endtask

    task automatic drain_services();
        i_in_valid <= 1'b0;
        @(posedge i_clk);
        while (pending_services.size() != 0) @(posedge i_clk);
        repeat (QUIET_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_start_track(input logic [TRACK_BITS-1:0] value);
        drain_services();
        i_cfg_we    <= 1'b1;
        i_cfg_wdata <= value;
        head_start = value;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        start_writes++;
    endtask

    task automatic check_field(input string field, input logic [31:0] want,
                               input logic [31:0] got);
        if (got !== want) begin
            $display("%0t: %s mismatch, expected %0h actual %0h", $time, field, want, got);
            error_count++;
        end
    endtask

    task automatic test_single_request();
        send_request(8'h5A, 12'hA5A, 1'b1);
    endtask

    // full batch from the top track with a request past capacity carrying the last mark
    task automatic test_full_batch_overflow();
        int i;
        write_start_track(TRACK_MAX);
        for (i = 0; i <= MAX_REQUESTS; i++) begin
            if (i == 0) send_request('0, '0, 1'b0);
            else if (i == 1) send_request(ID_MAX, TRACK_MAX, 1'b0);
            else send_request(ID_BITS'(i * 17), TRACK_BITS'($urandom), i == MAX_REQUESTS);
        end
    endtask

    task automatic test_ties_and_reversal();
        write_start_track(12'd2000);
        send_request(8'd1, 12'd2500, 1'b0);
        send_request(8'd2, 12'd1500, 1'b0);
        send_request(8'd3, 12'd2000, 1'b0);
        send_request(8'd4, 12'd1500, 1'b0);
        send_request(8'd5, 12'd2500, 1'b1);
    endtask

    task automatic test_config_mid_batch();
        send_request(8'h11, 12'h064, 1'b0);
        send_request(8'h22, 12'hFA0, 1'b0);
        write_start_track(12'h800);
        send_request(8'h33, 12'h7FF, 1'b1);
    endtask

    // output held off long enough that the block fills and stalls the input
    task automatic test_backpressure();
        int i;
        in_idling = 1'b0;
        stall_hold_len = HOLD_CYCLES;
        for (i = 0; i < MAX_REQUESTS; i++)
            send_request(ID_BITS'($urandom), TRACK_BITS'($urandom), i == MAX_REQUESTS - 1);
        for (i = 0; i < 6; i++)
            send_request(ID_BITS'($urandom), TRACK_BITS'($urandom), i == 5);
        in_idling = 1'b1;
    endtask

    task automatic test_random_batches(input int item_goal);
        int                    loaded;
        int                    n;
        int                    span;
        int                    pick;
        int                    i;
        logic [TRACK_BITS-1:0] base;
        loaded = 0;
        while (loaded < item_goal) begin
            pick = $urandom_range(0, 9);
            if (pick == 0) n = $urandom_range(MAX_REQUESTS + 1, MAX_REQUESTS + 3);
            else if (pick < 3) n = MAX_REQUESTS;
            else n = $urandom_range(1, MAX_REQUESTS);
            span = ($urandom_range(0, 2) == 0) ? 7 : int'(TRACK_MAX);
            if ($urandom_range(0, 1) == 1) base = head_start - TRACK_BITS'(span / 2);
            else base = TRACK_BITS'($urandom_range(0, TRACK_MAX));
            for (i = 0; i < n; i++)
                send_request(ID_BITS'($urandom_range(0, ID_MAX)),
                             base + TRACK_BITS'($urandom_range(0, span)), i == n - 1);
            loaded += (n > MAX_REQUESTS) ? MAX_REQUESTS : n;
        end
    endtask

    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (pending_services.size() == 0) begin
                $display("%0t: unexpected served beat, expected none actual id %0h track %0h",
                         $time, o_out_data.served_id, o_out_data.served_track);
                error_count++;
            end else begin
                service_want = pending_services.pop_front();
                services_checked++;
                check_field("served_id", 32'(service_want.served_id), 32'(o_out_data.served_id));
                check_field("served_track", 32'(service_want.served_track),
                            32'(o_out_data.served_track));
                check_field("seek_distance", 32'(service_want.seek_distance),
                            32'(o_out_data.seek_distance));
                check_field("seek_total", 32'(service_want.seek_total),
                            32'(o_out_data.seek_total));
                check_field("last_served", 32'(service_want.last_served),
                            32'(o_out_data.last_served));
            end
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || (i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("%0t: timeout, no beat for %0d cycles, %0d results outstanding",
                     $time, idle_cycles, pending_services.size());
            $display("elevator_disk_scheduler_top_tb NOT OK");
            $finish;
        end
    end

    initial begin
        int span;
        i_out_stall = 1'b0;
        @(posedge i_clk);
        forever begin
            if (stall_hold_len != 0) begin
                i_out_stall <= 1'b1;
                span = stall_hold_len;
                stall_hold_len = 0;
            end else if (out_idling && $urandom_range(0, 2) == 0) begin
                i_out_stall <= 1'b1;
                span = $urandom_range(1, 18);
            end else begin
                i_out_stall <= 1'b0;
                span = out_idling ? $urandom_range(1, 24) : 1;
            end
            repeat (span) @(posedge i_clk);
        end
    end

    initial begin
        int ph;
        i_rst_n     = 1'b0;
        i_cfg_we    = 1'b0;
        i_cfg_wdata = '0;
        i_in_valid  = 1'b0;
        i_in_data   = '0;
        head_start  = '0;
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;

        test_single_request();
        test_full_batch_overflow();
        test_ties_and_reversal();
        test_config_mid_batch();
        test_backpressure();
        for (ph = 0; ph < 5; ph++) begin
            if (ph == 0) write_start_track('0);
            else if (ph == 1) write_start_track(TRACK_MAX);
            else write_start_track(TRACK_BITS'($urandom_range(0, TRACK_MAX)));
            test_random_batches(27);
        end
        write_start_track(TRACK_BITS'($urandom_range(0, TRACK_MAX)));
        in_idling  = 1'b0;
        out_idling = 1'b0;
        test_random_batches(35);
        drain_services();
        repeat (2 * MAX_REQUESTS) @(posedge i_clk);

        $display("covered %0d batches, %0d served beats checked, %0d requests dropped past capacity",
                 batches_closed, services_checked, dropped_requests);
        $display("covered %0d start track writes incl. both extremes, long output hold, input stall",
                 start_writes);
        if (error_count == 0)
            $display("elevator_disk_scheduler_top_tb OK");
        else
            $display("elevator_disk_scheduler_top_tb NOT OK");
        $finish;
    end

endmodule
